FILE: design/ffra_pkg.sv
package ffra_pkg;

    localparam int MAX_RANGES = 64;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam int ID_W       = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 1;

    localparam int IN_TDATA_W  = 2 * ID_W;
    localparam int OUT_FIELD_W = 3 + ID_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [ID_W-1:0]       BOUND_RESET = ID_W'(32767);
    localparam logic [CFG_ADDR_W-1:0] ADDR_BOUND  = '0;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0] high;
        logic [ID_W-1:0] low;
    } t_entry;

    // controller -> chain
    typedef struct packed {
        logic   shift;
        t_entry tail;
    } t_chain_ctl;

    // chain -> controller: the two cells nearest the head
    typedef struct packed {
        t_entry second;
        t_entry head;
    } t_chain_view;

endpackage

FILE: design/first_fit_range_allocator.sv
// First-fit range allocator.
// Input stream: one command item per transfer; tuser selects allocate (0) or
// free (1), tdata carries the requested count and the start of a range to free.
// Output stream: one result item per command with a status code and, for a
// successful allocate, the start of the new range (0 otherwise).
// The held ranges live in a chain of 64 cells that rotates once per command
// (not for an allocate of zero); the controller looks at the head cell, finds
// the first gap that fits or the matching start, and splices entries in or out
// at the tail as they pass. Every other command waits for the full turn of
// the cell chain before its result. One item is in work at a time; the next
// is taken once the result has moved to the output register.
// The APB register space_upper_bound (byte address 0) is to be written only
// while idle; the block itself does not enforce it.
// Reset empties the table and sets the bound to 32767; no clearing pass.
// When the receiver stalls, the result waits in the output register and a
// further finished result holds the controller until that register frees.
module first_fit_range_allocator
    import ffra_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // count, start_req
    input  logic                   i_s_axis_tuser,   // command
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // status, range_start, zero pad
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [ID_W-1:0] r_bound;
    t_chain_ctl      chain_ctl;
    t_chain_view     chain_view;
    t_status         status;
    logic [ID_W-1:0] range_start;
    t_cmd            cmd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= BOUND_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_BOUND) begin
            r_bound <= pwdata;
        end
    end

    assign prdata = (paddr == ADDR_BOUND) ? r_bound : '0;

    assign cmd = t_cmd'(i_s_axis_tuser);

    ffra_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bound       (r_bound),
        .i_s_valid     (i_s_axis_tvalid),
        .o_s_ready     (o_s_axis_tready),
        .i_cmd         (cmd),
        .i_count       (i_s_axis_tdata[ID_W-1:0]),
        .i_start_req   (i_s_axis_tdata[2*ID_W-1:ID_W]),
        .o_m_valid     (o_m_axis_tvalid),
        .i_m_ready     (i_m_axis_tready),
        .o_status      (status),
        .o_range_start (range_start),
        .o_chain       (chain_ctl),
        .i_view        (chain_view)
    );

    ffra_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (chain_ctl),
        .o_view (chain_view)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), range_start, status};

endmodule

FILE: design/ffra_cell.sv
module ffra_cell
    import ffra_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_next,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: design/ffra_chain.sv
module ffra_chain
    import ffra_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctl  i_ctl,
    output t_chain_view o_view
);

    t_entry cell_q [MAX_RANGES];

    // entries move one cell towards the head on every shift; the tail is fed
    // by the controller
    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        t_entry nxt;
        if (g == MAX_RANGES - 1) begin : g_tail
            assign nxt = i_ctl.tail;
        end else begin : g_mid
            assign nxt = cell_q[g+1];
        end

        ffra_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_next  (nxt),
            .o_entry (cell_q[g])
        );
    end

    assign o_view.head   = cell_q[0];
    assign o_view.second = cell_q[1];

endmodule

FILE: design/ffra_ctrl.sv
module ffra_ctrl
    import ffra_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [ID_W-1:0]        i_bound,
    input  logic                   i_s_valid,
    output logic                   o_s_ready,
    input  t_cmd                   i_cmd,
    input  logic [ID_W-1:0]        i_count,
    input  logic [ID_W-1:0]        i_start_req,
    output logic                   o_m_valid,
    input  logic                   i_m_ready,
    output t_status                o_status,
    output logic [ID_W-1:0]        o_range_start,
    output t_chain_ctl             o_chain,
    input  t_chain_view            i_view
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    function automatic logic gap_fits(input logic [ID_W-1:0] lo,
                                      input logic [ID_W-1:0] hi,
                                      input logic [ID_W-1:0] req);
        logic [ID_W:0] diff;
        diff = {1'b0, hi} - {1'b0, lo};
        return !diff[ID_W] && (diff[ID_W-1:0] >= req);
    endfunction

    t_state          r_state, n_state;
    t_cmd            r_cmd;
    logic [ID_W-1:0] r_req, r_first;
    logic            r_zero;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_step;
    logic [ID_W-1:0] r_prev_high;
    logic            r_found, n_found;
    logic [ID_W-1:0] r_start, n_start;
    t_entry          r_carry, n_carry;
    logic            r_out_valid;
    t_status         r_out_status;
    logic [ID_W-1:0] r_out_start;

    logic            accept, out_free, load_out;
    logic            in_table, gap_ok, full, fit, match;
    logic [ID_W-1:0] gap_hi;
    t_entry          new_entry, tail;
    t_status         res_status;
    logic [ID_W-1:0] res_start;

    assign accept   = i_s_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_m_ready;
    assign load_out = (r_state == S_DONE) && out_free;

    assign in_table = CNT_W'(r_step) <  r_count;
    assign gap_ok   = CNT_W'(r_step) <= r_count;
    assign full     = r_count == CNT_W'(MAX_RANGES);

    // gap before the head entry; past the last held range it runs to the bound
    assign gap_hi = in_table ? i_view.head.low : i_bound;
    assign fit    = gap_ok && !r_found && gap_fits(r_prev_high, gap_hi, r_req);
    assign match  = in_table && (i_view.head.low == r_first);

    assign new_entry.low  = r_prev_high;
    assign new_entry.high = r_prev_high + r_req;

    always_comb begin
        tail    = i_view.head;
        n_found = r_found;
        n_start = r_start;
        n_carry = r_carry;
        if (r_cmd == CMD_ALLOC) begin
            if (fit) begin
                n_found = 1'b1;
                n_start = r_prev_high;
                if (!full) begin
                    tail    = new_entry;
                    n_carry = i_view.head;
                end
            end else if (r_found && !full) begin
                // one-item delay line pushes the rest up by one slot
                tail    = r_carry;
                n_carry = i_view.head;
            end
        end else begin
            if (r_found || match) begin
                tail    = i_view.second;
                n_found = 1'b1;
            end
        end
    end

    assign o_chain.shift = (r_state == S_SCAN);
    assign o_chain.tail  = tail;

    always_comb begin
        res_status = ST_NOSPACE;
        res_start  = '0;
        n_count    = r_count;
        if (r_zero) begin
            res_status = ST_ZERO;
        end else if (r_cmd == CMD_ALLOC) begin
            if (r_found) begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    res_status = ST_OK;
                    res_start  = r_start;
                    n_count    = r_count + CNT_W'(1);
                end
            end else if (full && gap_fits(r_prev_high, i_bound, r_req)) begin
                // gap after the last range of a full table
                res_status = ST_FULL;
            end
        end else begin
            if (r_found) begin
                res_status = ST_OK;
                n_count    = r_count - CNT_W'(1);
            end else begin
                res_status = ST_NOTFOUND;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_cmd == CMD_ALLOC && i_count == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_step == IDX_W'(MAX_RANGES - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= i_cmd;
            r_req       <= i_count;
            r_first     <= i_start_req;
            r_zero      <= (i_cmd == CMD_ALLOC) && (i_count == '0);
            r_step      <= '0;
            r_prev_high <= '0;
            r_found     <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_step      <= r_step + IDX_W'(1);
            r_prev_high <= i_view.head.high;
            r_found     <= n_found;
            r_start     <= n_start;
            r_carry     <= n_carry;
        end
        if (load_out) begin
            r_out_status <= res_status;
            r_out_start  <= res_start;
        end
    end

    assign o_s_ready     = (r_state == S_IDLE);
    assign o_m_valid     = r_out_valid;
    assign o_status      = r_out_status;
    assign o_range_start = r_out_start;

endmodule

FILE: verif/ffra_range_checker.sv
module ffra_range_checker
    import ffra_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_TDATA_W-1:0]  i_in_data,    // count, start_req
    input  logic                   i_in_cmd,     // command
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,   // status, range_start, zero pad
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    input  logic                   pready,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] start;
    } t_outcome;

    logic [ID_W-1:0] held_low  [MAX_RANGES];
    logic [ID_W-1:0] held_high [MAX_RANGES];
    int              held_num;
    logic [ID_W-1:0] id_bound;
    t_outcome        awaited [$];
    int              errors;
    int              results_seen;

    // First-fit search over the gaps, in 64-bit signed terms so that a gap
    // ending below its start (bound lowered under held ranges) counts as empty.
    function automatic t_outcome claim_range(logic [ID_W-1:0] req);
        int       slot;
        int       i;
        longint   gap_lo;
        longint   gap_hi;
        longint   need;
        t_outcome res;
        res.start = '0;
        if (req == '0) begin
            res.status = ST_ZERO;
            return res;
        end
        need   = {32'h0, req};
        slot   = 0;
        gap_lo = 0;
        gap_hi = (held_num == 0) ? {32'h0, id_bound} : {32'h0, held_low[0]};
        while ((gap_hi - gap_lo) < need && slot < held_num) begin
            gap_lo = {32'h0, held_high[slot]};
            slot++;
            gap_hi = (slot >= held_num) ? {32'h0, id_bound} : {32'h0, held_low[slot]};
        end
        if ((gap_hi - gap_lo) < need) begin
            res.status = ST_NOSPACE;
            return res;
        end
        if (held_num >= MAX_RANGES) begin
            res.status = ST_FULL;
            return res;
        end
        for (i = held_num; i > slot; i--) begin
            held_low[i]  = held_low[i-1];
            held_high[i] = held_high[i-1];
        end
        held_low[slot]  = gap_lo[ID_W-1:0];
        held_high[slot] = gap_lo[ID_W-1:0] + req;
        held_num++;
        res.status = ST_OK;
        res.start  = gap_lo[ID_W-1:0];
        return res;
    endfunction

    function automatic t_status release_range(logic [ID_W-1:0] first_id);
        int slot;
        int i;
        slot = 0;
        while (slot < held_num && held_low[slot] < first_id)
            slot++;
        if (slot >= held_num || held_low[slot] != first_id)
            return ST_NOTFOUND;
        for (i = slot; i + 1 < held_num; i++) begin
            held_low[i]  = held_low[i+1];
            held_high[i] = held_high[i+1];
        end
        held_num--;
        return ST_OK;
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        $display("result %0d: %s mismatch, expected %0h, got %0h",
                 results_seen, what, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome res;
        if (!i_rst_n) begin
            held_num = 0;
            id_bound = BOUND_RESET;
            awaited.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_BOUND)
                id_bound = pwdata[ID_W-1:0];
            // results first: an item taken this cycle cannot have its result yet
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (awaited.size() == 0) begin
                    report_mismatch("pending items", 1, 0);
                end else begin
                    want = awaited.pop_front();
                    if (i_out_data[2:0] != want.status)
                        report_mismatch("status", want.status, i_out_data[2:0]);
                    if (i_out_data[3 +: ID_W] != want.start)
                        report_mismatch("range_start", want.start, i_out_data[3 +: ID_W]);
                    if (i_out_data[OUT_TDATA_W-1:OUT_FIELD_W] != '0)
                        report_mismatch("pad", 0, i_out_data[OUT_TDATA_W-1:OUT_FIELD_W]);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (t_cmd'(i_in_cmd) == CMD_ALLOC) begin
                    res = claim_range(i_in_data[ID_W-1:0]);
                end else begin
                    res.start  = '0;
                    res.status = release_range(i_in_data[2*ID_W-1:ID_W]);
                end
                awaited.push_back(res);
            end
        end
        o_mismatches  <= errors;
        o_outstanding <= awaited.size();
    end

endmodule

FILE: verif/first_fit_range_allocator_test.sv
module first_fit_range_allocator_test;
    import ffra_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data  = '0;
    t_cmd                   s_cmd   = CMD_ALLOC;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr   = '0;
    logic [CFG_DATA_W-1:0]  pwdata  = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    int              mismatches;
    int              outstanding;
    bit              calm = 1'b0;
    int              quiet_cycles = 0;
    logic [ID_W-1:0] cur_bound = BOUND_RESET;
    t_cmd            cmds_in_flight [$];
    logic [ID_W-1:0] live_starts [$];

    first_fit_range_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_cmd),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    ffra_range_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_valid),
        .i_in_ready    (s_ready),
        .i_in_data     (s_data),
        .i_in_cmd      (s_cmd),
        .i_out_valid   (m_valid),
        .i_out_ready   (m_ready),
        .i_out_data    (m_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_ready <= calm || ($urandom_range(99) >= 7);
    end

    // Keeps the starts handed out so that most frees name a held range.
    always @(posedge i_clk) begin
        t_cmd done_cmd;
        if (i_rst_n) begin
            if (m_valid && m_ready && cmds_in_flight.size() > 0) begin
                done_cmd = cmds_in_flight.pop_front();
                if (done_cmd == CMD_ALLOC && t_status'(m_data[2:0]) == ST_OK)
                    live_starts.push_back(m_data[3 +: ID_W]);
            end
            if (s_valid && s_ready)
                cmds_in_flight.push_back(s_cmd);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("first_fit_range_allocator_test: done, errors");
                $finish;
            end
        end
    end

    task automatic send_item(t_cmd cmd, logic [ID_W-1:0] cnt, logic [ID_W-1:0] sreq);
        if (!calm) begin
            while ($urandom_range(99) < 7) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_data  <= {sreq, cnt};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic alloc(logic [ID_W-1:0] cnt);
        send_item(CMD_ALLOC, cnt, $urandom);
    endtask

    task automatic release_id(logic [ID_W-1:0] sreq);
        send_item(CMD_FREE, $urandom, sreq);
    endtask

    // Stop sending and let every result come out.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_bound(logic [ID_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BOUND;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cur_bound = value;
    endtask

    function automatic logic [ID_W-1:0] pick_count();
        int              r;
        logic [ID_W-1:0] span;
        r    = $urandom_range(99);
        span = cur_bound >> 5;
        if (r < 4)
            return '0;
        if (r < 10)
            return $urandom;
        if (r < 14)
            return cur_bound;
        return 1 + $urandom_range(span);
    endfunction

    function automatic logic [ID_W-1:0] pick_free_start();
        int              r;
        int              idx;
        logic [ID_W-1:0] sreq;
        r = $urandom_range(99);
        if (r < 75 && live_starts.size() > 0) begin
            idx  = $urandom_range(live_starts.size() - 1);
            sreq = live_starts[idx];
            live_starts.delete(idx);
            return sreq;
        end
        if (r < 90)
            return $urandom_range(cur_bound);
        return $urandom;
    endfunction

    task automatic run_phase(logic [ID_W-1:0] bound, int items, int alloc_pct);
        int n;
        set_bound(bound);
        for (n = 0; n < items; n++) begin
            if ($urandom_range(99) < alloc_pct)
                alloc(pick_count());
            else
                release_id(pick_free_start());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bound: zero request, empty free, exact fill, too large
        alloc('0);
        release_id('0);
        alloc(1);
        alloc(32766);
        alloc(1);
        alloc(32'hFFFF_FFFF);
        release_id(5);
        release_id('0);
        alloc(1);
        release_id(1);
        alloc(2);
        release_id(32'hFFFF_FFFF);
        release_id('0);
        release_id(1);

        // bound of zero: every gap is empty
        set_bound('0);
        alloc(1);
        alloc('0);

        // whole space in one range
        set_bound(32'hFFFF_FFFF);
        alloc(32'hFFFF_FFFF);
        alloc(1);
        release_id('0);
        alloc(32'h8000_0000);
        alloc(32'h7FFF_FFFF);
        release_id('0);
        release_id(32'h8000_0000);

        // bound lowered under held ranges
        set_bound(100);
        alloc(50);
        alloc(30);
        set_bound(20);
        alloc(1);
        release_id(50);
        release_id('0);
        live_starts.delete();

        run_phase(1000, 150, 60);
        run_phase(32'hFFFF_FFFF, 150, 85);
        run_phase(200, 120, 40);
        calm = 1'b1;
        run_phase(64, 150, 70);
        calm = 1'b0;
        run_phase($urandom, 150, 55);
        run_phase(1, 60, 50);
        run_phase(32767, 150, 50);
        run_phase(5000, 120, 65);

        drain();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("first_fit_range_allocator_test: done, clean");
        else
            $display("first_fit_range_allocator_test: done, errors");
        $finish;
    end

endmodule

FILE: files.f
design/ffra_pkg.sv
design/ffra_cell.sv
design/ffra_chain.sv
design/ffra_ctrl.sv
design/first_fit_range_allocator.sv
verif/ffra_range_checker.sv
verif/first_fit_range_allocator_test.sv
